[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define WAVHP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define WAVHP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

[hw/rtl/wavhp_pkg.sv]
package wavhp_pkg;

    // Tags as they sit in the little-endian field shift register
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Register reset values
    localparam logic [31:0] RATE_RESET     = 32'd8000;
    localparam logic [15:0] CHANNELS_RESET = 16'd1;
    localparam logic [15:0] BITS_RESET     = 16'd8;
    localparam logic [31:0] MAX_LEN_RESET  = 32'd16777216;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BITS     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN  = 2'd3;

    // Header byte offsets at which a field completes
    localparam int OFFSET_W = 6;
    localparam logic [OFFSET_W-1:0] OFF_RIFF     = 6'd3;
    localparam logic [OFFSET_W-1:0] OFF_WAVE     = 6'd11;
    localparam logic [OFFSET_W-1:0] OFF_FMT_SIZE = 6'd19;
    localparam logic [OFFSET_W-1:0] OFF_COMP     = 6'd21;
    localparam logic [OFFSET_W-1:0] OFF_CHANNELS = 6'd23;
    localparam logic [OFFSET_W-1:0] OFF_RATE     = 6'd27;
    localparam logic [OFFSET_W-1:0] OFF_BITS     = 6'd35;

    // Fmt fields read before the skip, and the length of a chunk id or size
    localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
    localparam logic [31:0] FIELD_BYTES  = 32'd4;
    localparam logic [15:0] PCM_CODE     = 16'd1;

    // Result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_RIFF     = 4'd1;
    localparam logic [3:0] ERR_WAVE     = 4'd2;
    localparam logic [3:0] ERR_COMP     = 4'd3;
    localparam logic [3:0] ERR_CHANNELS = 4'd4;
    localparam logic [3:0] ERR_RATE     = 4'd5;
    localparam logic [3:0] ERR_BITS     = 4'd6;
    localparam logic [3:0] ERR_LENGTH   = 4'd7;
    localparam logic [3:0] ERR_FMT_SIZE = 4'd8;

    typedef enum logic [3:0] {
        PH_HEADER     = 4'd0,
        PH_FMT_SKIP   = 4'd1,
        PH_CHUNK_ID   = 4'd2,
        PH_CHUNK_SIZE = 4'd3,
        PH_CHUNK_SKIP = 4'd4,
        PH_DATA_LEN   = 4'd5,
        PH_SAMPLES    = 4'd6,
        PH_DONE       = 4'd7,
        PH_ERROR      = 4'd8
    } phase_t;

    typedef struct packed {
        logic [31:0] expected_rate;
        logic [15:0] expected_channels;
        logic [15:0] expected_bits;
        logic [31:0] max_data_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  sample_byte;
        logic [31:0] data_length;
        logic [3:0]  error_code;
        logic        last_sample;
    } result_t;

endpackage

[hw/rtl/wavhp_cfg.sv]
module wavhp_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wavhp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                       cfg_data,
    output wavhp_pkg::cfg_t                   cfg
);

    wavhp_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Load the addressed register on a write transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_rate     <= wavhp_pkg::RATE_RESET;
            cfg_reg.expected_channels <= wavhp_pkg::CHANNELS_RESET;
            cfg_reg.expected_bits     <= wavhp_pkg::BITS_RESET;
            cfg_reg.max_data_length   <= wavhp_pkg::MAX_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                wavhp_pkg::REG_RATE:     cfg_reg.expected_rate     <= cfg_data;
                wavhp_pkg::REG_CHANNELS: cfg_reg.expected_channels <= cfg_data[15:0];
                wavhp_pkg::REG_BITS:     cfg_reg.expected_bits     <= cfg_data[15:0];
                wavhp_pkg::REG_MAX_LEN:  cfg_reg.max_data_length   <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[hw/rtl/wavhp_parser.sv]
module wavhp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic [7:0]          file_byte,
    input  logic                start_of_file,
    input  wavhp_pkg::cfg_t     cfg,
    output logic                res_valid,
    output wavhp_pkg::result_t  res
);

    wavhp_pkg::phase_t                 phase_reg, phase_next, phase_cur;
    logic [wavhp_pkg::OFFSET_W-1:0]    offset_reg, offset_next, offset_cur;
    logic [31:0]                       shift_reg, shift_next, shift_cur;
    logic [31:0]                       fmt_size_reg, fmt_size_next, fmt_size_cur;
    logic [31:0]                       skip_reg, skip_next, skip_cur, skip_dec;
    logic [31:0]                       data_reg, data_next, data_cur, data_dec;

    // Restart the parse state when the byte opens a new file
    always_comb begin
        phase_cur    = start_of_file ? wavhp_pkg::PH_HEADER : phase_reg;
        offset_cur   = start_of_file ? '0 : offset_reg;
        shift_cur    = start_of_file ? '0 : shift_reg;
        fmt_size_cur = start_of_file ? '0 : fmt_size_reg;
        skip_cur     = start_of_file ? '0 : skip_reg;
        data_cur     = start_of_file ? '0 : data_reg;
    end

    assign shift_next = {file_byte, shift_cur[31:8]};
    assign skip_dec   = skip_cur - 32'd1;
    assign data_dec   = data_cur - 32'd1;

    // Next phase and field registers
    always_comb begin
        phase_next    = phase_cur;
        offset_next   = offset_cur;
        fmt_size_next = fmt_size_cur;
        skip_next     = skip_cur;
        data_next     = data_cur;
        unique case (phase_cur)
            wavhp_pkg::PH_HEADER: begin
                offset_next = offset_cur + {{(wavhp_pkg::OFFSET_W-1){1'b0}}, 1'b1};
                unique case (offset_cur)
                    wavhp_pkg::OFF_RIFF: begin
                        if (shift_next != wavhp_pkg::TAG_RIFF) phase_next = wavhp_pkg::PH_ERROR;
                    end
                    wavhp_pkg::OFF_WAVE: begin
                        if (shift_next != wavhp_pkg::TAG_WAVE) phase_next = wavhp_pkg::PH_ERROR;
                    end
                    wavhp_pkg::OFF_FMT_SIZE: fmt_size_next = shift_next;
                    wavhp_pkg::OFF_COMP: begin
                        if (shift_next[31:16] != wavhp_pkg::PCM_CODE)
                            phase_next = wavhp_pkg::PH_ERROR;
                    end
                    wavhp_pkg::OFF_CHANNELS: begin
                        if (shift_next[31:16] != cfg.expected_channels)
                            phase_next = wavhp_pkg::PH_ERROR;
                    end
                    wavhp_pkg::OFF_RATE: begin
                        if (shift_next != cfg.expected_rate) phase_next = wavhp_pkg::PH_ERROR;
                    end
                    wavhp_pkg::OFF_BITS: begin
                        if (shift_next[31:16] != cfg.expected_bits ||
                            fmt_size_cur < wavhp_pkg::FMT_MIN_SIZE) begin
                            phase_next = wavhp_pkg::PH_ERROR;
                        end else if (fmt_size_cur == wavhp_pkg::FMT_MIN_SIZE) begin
                            phase_next = wavhp_pkg::PH_CHUNK_ID;
                            skip_next  = wavhp_pkg::FIELD_BYTES;
                        end else begin
                            phase_next = wavhp_pkg::PH_FMT_SKIP;
                            skip_next  = fmt_size_cur - wavhp_pkg::FMT_MIN_SIZE;
                        end
                    end
                    default: ;
                endcase
            end
            wavhp_pkg::PH_FMT_SKIP, wavhp_pkg::PH_CHUNK_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    phase_next = wavhp_pkg::PH_CHUNK_ID;
                    skip_next  = wavhp_pkg::FIELD_BYTES;
                end
            end
            wavhp_pkg::PH_CHUNK_ID: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    phase_next = (shift_next == wavhp_pkg::TAG_DATA) ?
                                 wavhp_pkg::PH_DATA_LEN : wavhp_pkg::PH_CHUNK_SIZE;
                    skip_next  = wavhp_pkg::FIELD_BYTES;
                end
            end
            wavhp_pkg::PH_CHUNK_SIZE: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    if (shift_next == '0) begin
                        phase_next = wavhp_pkg::PH_CHUNK_ID;
                        skip_next  = wavhp_pkg::FIELD_BYTES;
                    end else begin
                        phase_next = wavhp_pkg::PH_CHUNK_SKIP;
                        skip_next  = shift_next;
                    end
                end
            end
            wavhp_pkg::PH_DATA_LEN: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    if (shift_next > cfg.max_data_length) begin
                        phase_next = wavhp_pkg::PH_ERROR;
                    end else begin
                        data_next  = shift_next;
                        phase_next = (shift_next != '0) ?
                                     wavhp_pkg::PH_SAMPLES : wavhp_pkg::PH_DONE;
                    end
                end
            end
            wavhp_pkg::PH_SAMPLES: begin
                data_next = data_dec;
                if (data_dec == '0) phase_next = wavhp_pkg::PH_DONE;
            end
            wavhp_pkg::PH_DONE, wavhp_pkg::PH_ERROR: ;
            default: phase_next = wavhp_pkg::PH_ERROR;
        endcase
    end

    // Result for the current byte
    always_comb begin
        res_valid       = 1'b0;
        res.result_kind = wavhp_pkg::KIND_HEADER;
        res.sample_byte = '0;
        res.data_length = '0;
        res.error_code  = wavhp_pkg::ERR_NONE;
        res.last_sample = 1'b0;
        unique case (phase_cur)
            wavhp_pkg::PH_HEADER: begin
                unique case (offset_cur)
                    wavhp_pkg::OFF_RIFF: begin
                        if (shift_next != wavhp_pkg::TAG_RIFF) begin
                            res_valid      = 1'b1;
                            res.error_code = wavhp_pkg::ERR_RIFF;
                        end
                    end
                    wavhp_pkg::OFF_WAVE: begin
                        if (shift_next != wavhp_pkg::TAG_WAVE) begin
                            res_valid      = 1'b1;
                            res.error_code = wavhp_pkg::ERR_WAVE;
                        end
                    end
                    wavhp_pkg::OFF_COMP: begin
                        if (shift_next[31:16] != wavhp_pkg::PCM_CODE) begin
                            res_valid      = 1'b1;
                            res.error_code = wavhp_pkg::ERR_COMP;
                        end
                    end
                    wavhp_pkg::OFF_CHANNELS: begin
                        if (shift_next[31:16] != cfg.expected_channels) begin
                            res_valid      = 1'b1;
                            res.error_code = wavhp_pkg::ERR_CHANNELS;
                        end
                    end
                    wavhp_pkg::OFF_RATE: begin
                        if (shift_next != cfg.expected_rate) begin
                            res_valid      = 1'b1;
                            res.error_code = wavhp_pkg::ERR_RATE;
                        end
                    end
                    wavhp_pkg::OFF_BITS: begin
                        if (shift_next[31:16] != cfg.expected_bits) begin
                            res_valid      = 1'b1;
                            res.error_code = wavhp_pkg::ERR_BITS;
                        end else if (fmt_size_cur < wavhp_pkg::FMT_MIN_SIZE) begin
                            res_valid      = 1'b1;
                            res.error_code = wavhp_pkg::ERR_FMT_SIZE;
                        end
                    end
                    default: ;
                endcase
                if (res_valid) res.result_kind = wavhp_pkg::KIND_ERROR;
            end
            wavhp_pkg::PH_DATA_LEN: begin
                if (skip_dec == '0) begin
                    res_valid = 1'b1;
                    if (shift_next > cfg.max_data_length) begin
                        res.result_kind = wavhp_pkg::KIND_ERROR;
                        res.error_code  = wavhp_pkg::ERR_LENGTH;
                    end else begin
                        res.data_length = shift_next;
                        res.last_sample = (shift_next == '0);
                    end
                end
            end
            wavhp_pkg::PH_SAMPLES: begin
                res_valid       = 1'b1;
                res.result_kind = wavhp_pkg::KIND_SAMPLE;
                res.sample_byte = file_byte;
                res.last_sample = (data_dec == '0);
            end
            default: ;
        endcase
    end

    // Advance the parse state on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= wavhp_pkg::PH_HEADER;
            offset_reg   <= '0;
            shift_reg    <= '0;
            fmt_size_reg <= '0;
            skip_reg     <= '0;
            data_reg     <= '0;
        end else if (in_fire) begin
            phase_reg    <= phase_next;
            offset_reg   <= offset_next;
            shift_reg    <= shift_next;
            fmt_size_reg <= fmt_size_next;
            skip_reg     <= skip_next;
            data_reg     <= data_next;
        end
    end

endmodule

[hw/rtl/wavhp_out_reg.sv]
module wavhp_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  wavhp_pkg::result_t res,
    output logic               room,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    logic               valid_reg;
    wavhp_pkg::result_t res_reg;

    // Space for a new result when empty or when the held one leaves now
    assign room     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0, res_reg.error_code, res_reg.data_length, res_reg.sample_byte};
    assign m_tuser  = res_reg.result_kind;
    assign m_tlast  = res_reg.last_sample;

    // Hold the result until its transfer, then drop or replace it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

[hw/rtl/wav_header_parser.sv]
// Latency: a result is shown on the m_ side in the cycle after its input transfer.
// Throughput: one file byte per cycle; the single output register takes a new
// result in the cycle its old one transfers, so s_tready falls only under m_tready low.
// Reset (aresetn low, synchronous): registers return to their defaults, the parser
// waits for the RIFF tag and the output register is emptied.
module wav_header_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [7:0] file_byte
    input  logic                              s_tuser,  // [0] start_of_file
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] sample_byte, [39:8] data_length, [43:40] error_code, [47:44] zero
    output logic [47:0]                       m_tdata,
    output logic [1:0]                        m_tuser,  // [1:0] result_kind
    output logic                              m_tlast,  // last_sample
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wavhp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                       cfg_data
);

    wavhp_pkg::cfg_t    cfg;
    wavhp_pkg::result_t res;
    logic               res_valid;
    logic               room;
    logic               in_fire;

    assign s_tready = room;
    assign in_fire  = s_tvalid && s_tready;

    wavhp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wavhp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .file_byte     (s_tdata),
        .start_of_file (s_tuser),
        .cfg           (cfg),
        .res_valid     (res_valid),
        .res           (res)
    );

    wavhp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (in_fire && res_valid),
        .res      (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[hw/rtl/wavhp_checker.sv]
`include "assert_macros.svh"

module wavhp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    logic        stalled;
    logic [50:0] m_beat;
    logic [3:0]  m_err;
    logic        err_ok;
    logic        len_zero;
    logic        is_err;
    logic        is_sample;
    logic        is_header;

    // Decode the result side for the properties below
    assign stalled   = m_tvalid && !m_tready;
    assign m_beat    = {m_tlast, m_tuser, m_tdata};
    assign m_err     = m_tdata[43:40];
    assign err_ok    = m_err != wavhp_pkg::ERR_NONE && m_err <= wavhp_pkg::ERR_FMT_SIZE
                       && m_tdata[39:0] == 40'd0 && !m_tlast;
    assign len_zero  = (m_tdata[39:8] == 32'd0);
    assign is_err    = m_tvalid && m_tuser == wavhp_pkg::KIND_ERROR;
    assign is_sample = m_tvalid && m_tuser == wavhp_pkg::KIND_SAMPLE;
    assign is_header = m_tvalid && m_tuser == wavhp_pkg::KIND_HEADER;

    // A stalled result holds its payload
    `WAVHP_ASSERT(a_out_hold, stalled |=> m_tvalid && $stable(m_beat), "stalled result changed")

    // An error result carries a known error code and nothing else
    `WAVHP_ASSERT(a_err_code, is_err |-> err_ok, "bad error result")

    // A sample result has no length and no error code
    `WAVHP_ASSERT(a_sample_clean, is_sample |-> m_tdata[47:8] == 40'd0, "sample result has stray fields")

    // A header result marks last exactly when its length is zero
    `WAVHP_ASSERT(a_header_last, is_header |-> m_tlast == len_zero && m_tdata[7:0] == 8'd0, "header last mark wrong")

    // Reset empties the output side
    `WAVHP_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind wav_header_parser wavhp_checker u_wavhp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
